>>> src/iois_pkg.sv
// ----------------------------------------------------------------------------
// iois_pkg
// Shared types and constants for the insertion-ordered integer set core.
// ----------------------------------------------------------------------------
package iois_pkg;

  // Capacity of the set, and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the channels.
  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_EXISTS = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIRST  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd4;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the operation and the registered compare
    logic exec;  // apply the update and load the result register
  } cmd_t;

endpackage

>>> src/iois_ctrl.sv
// ----------------------------------------------------------------------------
// iois_ctrl
// Controller: sequences one operation over a compare cycle and an execute
// cycle, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module iois_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output iois_pkg::cmd_t  cmd
);

  iois_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iois_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = iois_pkg::ST_EXEC;
      end
      iois_pkg::ST_EXEC: begin
        if (out_free) state_nxt = iois_pkg::ST_IDLE;
      end
      default: state_nxt = iois_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      iois_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      iois_pkg::ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Result valid flag: set by an execute, cleared by an output transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iois_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A new result appears only from an execute cycle.
  a_rise_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == iois_pkg::ST_EXEC))
    else $error("result valid rose outside an execute cycle");

  // Input transfers happen only while idle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == iois_pkg::ST_IDLE) && !cmd.exec)
    else $error("input transfer outside idle");

  // An execute never overwrites a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && out_stall))
    else $error("stalled result overwritten");

  // Every load is followed by the execute cycle.
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == iois_pkg::ST_EXEC))
    else $error("load not followed by execute state");

endmodule

>>> src/iois_dp.sv
// ----------------------------------------------------------------------------
// iois_dp
// Datapath: entry cells with a parallel compare, shift-down on removal,
// count and cursor registers, and the result register.
// ----------------------------------------------------------------------------
module iois_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  iois_pkg::cmd_t                       cmd,
  input  logic [iois_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [iois_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_present,
  output logic                                 out_has_item,
  output logic signed [iois_pkg::VALUE_W-1:0]  out_item,
  output logic [iois_pkg::COUNT_W-1:0]         out_count,
  output logic                                 out_overflow
);

  localparam int DEPTH = iois_pkg::DEPTH;
  localparam int IDX_W = iois_pkg::IDX_W;
  localparam int CNT_W = iois_pkg::CNT_W;
  localparam int VW    = iois_pkg::VALUE_W;

  logic [VW-1:0]             entries_r [DEPTH];
  logic [CNT_W-1:0]          used_r, used_nxt;
  logic [CNT_W-1:0]          cursor_r, cursor_nxt;
  logic [iois_pkg::FUNC_W-1:0] func_r;
  logic [VW-1:0]             value_r;
  logic [DEPTH-1:0]          match_r, match_c;
  logic [DEPTH-1:0]          tail_r, tail_c;
  logic                      found_r;

  logic                      full;
  logic                      do_insert;
  logic                      do_remove;
  logic                      pres_nxt, has_nxt, ovf_nxt;
  logic [VW-1:0]             item_nxt;

  // Parallel compare of the incoming value against every live cell, and the
  // prefix of the match that marks the cells at and after the hit.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_c[i] = (entries_r[i] == in_value) && (CNT_W'(i) < used_r);
    end
    tail_c[0] = match_c[0];
    for (int i = 1; i < DEPTH; i++) begin
      tail_c[i] = tail_c[i-1] | match_c[i];
    end
  end

  // Capture the operation together with its compare result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      value_r <= in_value;
      match_r <= match_c;
      tail_r  <= tail_c;
      found_r <= |match_c;
    end
  end

  assign full      = (used_r >= CNT_W'(DEPTH));
  assign do_insert = (func_r == iois_pkg::FN_INSERT) && !found_r && !full;
  assign do_remove = (func_r == iois_pkg::FN_REMOVE) && found_r;

  // Result and the next count and cursor.
  always_comb begin
    used_nxt   = used_r;
    cursor_nxt = cursor_r;
    pres_nxt   = 1'b0;
    has_nxt    = 1'b0;
    ovf_nxt    = 1'b0;
    item_nxt   = '0;
    case (func_r)
      iois_pkg::FN_INSERT: begin
        pres_nxt = found_r;
        if (!found_r) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            used_nxt = used_r + CNT_W'(1);
            if (cursor_r > CNT_W'(1)) cursor_nxt = CNT_W'(1);
          end
        end
      end
      iois_pkg::FN_REMOVE: begin
        pres_nxt = found_r;
        if (found_r) used_nxt = used_r - CNT_W'(1);
        if (cursor_r > CNT_W'(1)) cursor_nxt = CNT_W'(1);
      end
      iois_pkg::FN_EXISTS: begin
        pres_nxt = found_r;
      end
      iois_pkg::FN_FIRST: begin
        if (used_r != '0) begin
          has_nxt    = 1'b1;
          item_nxt   = entries_r[0];
          cursor_nxt = CNT_W'(1);
        end
      end
      iois_pkg::FN_NEXT: begin
        if (cursor_r < used_r) begin
          has_nxt    = 1'b1;
          item_nxt   = entries_r[cursor_r[IDX_W-1:0]];
          cursor_nxt = cursor_r + CNT_W'(1);
        end
      end
      default: begin
        pres_nxt = 1'b0;
      end
    endcase
  end

  // Entry cells: append at the count, or close the gap after a removal.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_insert) begin
        entries_r[used_r[IDX_W-1:0]] <= value_r;
      end else if (do_remove) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (tail_r[i]) entries_r[i] <= entries_r[i+1];
        end
      end
    end
  end

  // Count and cursor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      cursor_r <= '0;
    end else if (cmd.exec) begin
      used_r   <= used_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // Result register, loaded by the execute cycle.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_present  <= pres_nxt;
      out_has_item <= has_nxt;
      out_item     <= item_nxt;
      out_count    <= iois_pkg::COUNT_W'(used_nxt);
      out_overflow <= ovf_nxt;
    end
  end

  // Values in the set are distinct, so at most one cell matches.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $onehot0(match_r))
    else $error("more than one cell matched");

  // The count never exceeds the capacity.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  // An overflow leaves the count at capacity.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && ovf_nxt |=> used_r == CNT_W'(DEPTH))
    else $error("overflow reported while not full");

  // Removal of a present value lowers the count by one.
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && do_remove |=> used_r == $past(used_r) - CNT_W'(1))
    else $error("removal did not lower the count");

endmodule

>>> src/insertion_ordered_int_set_core.sv
// ----------------------------------------------------------------------------
// insertion_ordered_int_set_core
// Set of distinct signed 32-bit values kept in insertion order, with insert,
// remove, exists, first and next operations; one result per operation.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   func, value
//   out_     output     out_valid / out_stall present, has_item, item, count,
//                                             overflow
//
// Each operation is first captured, registering the parallel compare over all
// cells, and then executed, updating cells, count and cursor and loading the
// result register. The input is stalled while the execute state lasts.
// The execute cycle waits while a previous result is stalled at the output;
// a new operation can be taken while a result waits.
// Reset is synchronous and clears the count, cursor and handshake state; the
// cells need no clearing.
// ----------------------------------------------------------------------------
module insertion_ordered_int_set_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [iois_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [iois_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_present,
  output logic                                 out_has_item,
  output logic signed [iois_pkg::VALUE_W-1:0]  out_item,
  output logic [iois_pkg::COUNT_W-1:0]         out_count,
  output logic                                 out_overflow
);

  iois_pkg::cmd_t cmd;

  // Operation sequencing and handshakes.
  iois_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Cells, count, cursor and result register.
  iois_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_present  (out_present),
    .out_has_item (out_has_item),
    .out_item     (out_item),
    .out_count    (out_count),
    .out_overflow (out_overflow)
  );

endmodule
